// File: src/ssd_pkg.sv
// Package for the seven-segment display controller.
// Holds payload and control types, command and register codes, glyph and lamp tables.
// No dependencies.
package ssd_pkg;

    localparam int PAGES_DEFAULT  = 4;
    localparam int BYTES_PER_PAGE = 7;
    localparam int DIGITS         = 6;
    localparam int PADDR_W        = 4;

    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_CHAR  = 3'd1;
    localparam logic [2:0] CMD_IND   = 3'd2;
    localparam logic [2:0] CMD_DOTS  = 3'd3;
    localparam logic [2:0] CMD_ALL   = 3'd4;
    localparam logic [2:0] CMD_FILL  = 3'd5;
    localparam logic [2:0] CMD_LATCH = 3'd6;
    localparam logic [2:0] CMD_SCAN  = 3'd7;

    localparam logic [1:0] REG_LAYOUT = 2'd0;
    localparam logic [1:0] REG_ENABLE = 2'd1;
    localparam logic [1:0] REG_EDIT   = 2'd2;
    localparam logic [1:0] REG_SHOWN  = 2'd3;

    typedef struct packed {
        logic [2:0] command;
        logic [1:0] window;
        logic [2:0] position;
        logic [7:0] char_code;
        logic [5:0] indicator;
        logic       set_on;
        logic [2:0] decimal_pos;
        logic       thousand_point;
    } request_t;

    typedef struct packed {
        logic [7:0] segment_pattern;
        logic [2:0] digit_select;
    } result_t;

    typedef struct packed {
        logic [1:0] indicator_layout;
        logic       display_enable;
        logic [1:0] edit_page;
        logic [1:0] shown_page;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic tick;
        logic blank;
        logic rd;
        logic wr;
    } ctl_cmd_t;

    typedef struct packed {
        logic       skip;
        logic       is_clear;
        logic       is_latch;
        logic [2:0] first;
        logic [2:0] last;
    } ctl_status_t;

    localparam logic [7:0] GLYPHS [64] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00,
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h27,
        8'h7f, 8'h6f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71, 8'h6f,
        8'h76, 8'h04, 8'h1e, 8'h70, 8'h38, 8'h55, 8'h54, 8'h5c,
        8'h73, 8'h67, 8'h50, 8'h6d, 8'h78, 8'h3e, 8'h1c, 8'h1d,
        8'h49, 8'h6e, 8'h5b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08
    };

    localparam logic [7:0] LAMP_STD [16] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h20, 8'h02, 8'h04,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'h08, 8'h40
    };

    localparam logic [7:0] LAMP_ALT [16] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h20, 8'h02, 8'h04,
        8'h40, 8'h08, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00
    };

    function automatic logic [7:0] glyph_of(input logic [7:0] code);
        logic [7:0] c;
        logic [7:0] idx;
        c = code;
        if (c >= 8'h61 && c <= 8'h7a)
            c = c - 8'h20;
        if (c < 8'h20 || c > 8'h5f)
            c = 8'h20;
        idx = c - 8'h20;
        return GLYPHS[idx[5:0]];
    endfunction

    // layout 3 acts as layout 0; layouts 0 and 1 share a row
    function automatic logic [7:0] lamp_mask(input logic [1:0] layout, input logic [3:0] ind);
        logic [7:0] m;
        if (layout == 2'd2)
            m = LAMP_ALT[ind];
        else
            m = LAMP_STD[ind];
        return m;
    endfunction

    function automatic logic [7:0] lamp_union(input logic [1:0] layout);
        logic [7:0] m;
        m = 8'h00;
        for (int i = 0; i < 16; i++)
        begin
            m = m | lamp_mask(layout, 4'(i));
        end
        return m;
    endfunction

endpackage

// File: src/seven_segment_display_controller.sv
// Top level of the multiplexed seven-segment display controller.
// Depends on ssd_pkg, ssd_regs, ssd_ctrl and ssd_dp.
//
// Usage:
//   Commands enter on request when start is high and busy is low. Scan ticks
//   produce a result transaction on result, marked by result_valid for one
//   cycle, in the cycle after the tick is accepted; busy stays low for a tick.
//   Other commands produce no result and hold busy while they run: a decode
//   step, then a read and write pair per byte (character write and single
//   indicator touch one byte; dots, fill, all indicators and latch several),
//   or for clear a sweep of every page. Ignored commands (bad window, page
//   or position) end after the decode step.
//   Edits walk the page memory one byte per read and write pair; clear sweeps
//   every memory entry at one per cycle.
//   Configuration is on the APB port, registers at byte addresses 0, 4, 8, 12;
//   write it only while busy is low.
//   Reset clears config, scan buffer, digit counter and the page valid bits,
//   so every page reads as blank at once with no clearing pass.
//   The receiver cannot stall: each result is taken in the cycle it is shown.
module seven_segment_display_controller #(
    parameter int PAGES = ssd_pkg::PAGES_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  ssd_pkg::request_t           request,
    output ssd_pkg::result_t            result,
    output logic                        result_valid,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int AW = $clog2(PAGES * ssd_pkg::BYTES_PER_PAGE);

    ssd_pkg::cfg_t        cfg;
    ssd_pkg::ctl_cmd_t    cmd;
    ssd_pkg::ctl_status_t status;
    logic [AW-1:0]        cnt;

    ssd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssd_ctrl #(
        .PAGES (PAGES),
        .AW    (AW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (request.command),
        .status  (status),
        .busy    (busy),
        .cmd     (cmd),
        .cnt     (cnt)
    );

    ssd_dp #(
        .PAGES (PAGES),
        .AW    (AW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cfg          (cfg),
        .cmd          (cmd),
        .cnt          (cnt),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while a command is in progress");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.digit_select != 3'd7))
        else $error("digit select out of range");

    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.command != ssd_pkg::CMD_SCAN) |=> busy)
        else $error("command accepted without going busy");

    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.command == ssd_pkg::CMD_SCAN) |=> result_valid)
        else $error("scan tick gave no result");

endmodule

// File: src/ssd_regs.sv
// Configuration register file on an APB-style port.
// Depends on ssd_pkg (cfg_t, register codes).
module ssd_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output ssd_pkg::cfg_t               cfg
);

    ssd_pkg::cfg_t cfg_reg;
    ssd_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                ssd_pkg::REG_LAYOUT: cfg_next.indicator_layout = pwdata[1:0];
                ssd_pkg::REG_ENABLE: cfg_next.display_enable   = pwdata[0];
                ssd_pkg::REG_EDIT:   cfg_next.edit_page        = pwdata[1:0];
                ssd_pkg::REG_SHOWN:  cfg_next.shown_page       = pwdata[1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            ssd_pkg::REG_LAYOUT: prdata = {30'd0, cfg_reg.indicator_layout};
            ssd_pkg::REG_ENABLE: prdata = {31'd0, cfg_reg.display_enable};
            ssd_pkg::REG_EDIT:   prdata = {30'd0, cfg_reg.edit_page};
            ssd_pkg::REG_SHOWN:  prdata = {30'd0, cfg_reg.shown_page};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

// File: src/ssd_ctrl.sv
// Sequencer for the display controller: decode, read-modify-write walk, clear sweep.
// Depends on ssd_pkg (ctl_cmd_t, ctl_status_t, command codes).
module ssd_ctrl #(
    parameter int PAGES = ssd_pkg::PAGES_DEFAULT,
    parameter int AW    = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [2:0]           command,
    input  ssd_pkg::ctl_status_t status,
    output logic                 busy,
    output ssd_pkg::ctl_cmd_t    cmd,
    output logic [AW-1:0]        cnt
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_CLEAR  = 3'd4;

    localparam logic [AW-1:0] LAST_ADDR = AW'(PAGES * ssd_pkg::BYTES_PER_PAGE - 1);

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;

    assign busy = (state_reg != S_IDLE);
    assign cnt  = cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (command == ssd_pkg::CMD_SCAN)
                        cmd.tick = 1'b1;
                    else
                        state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.skip)
                begin
                    cmd.blank  = status.is_latch;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next   = AW'(status.first);
                    state_next = status.is_clear ? S_CLEAR : S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.wr = 1'b1;
                if (cnt_reg[2:0] == status.last)
                    state_next = S_IDLE;
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_CLEAR:
            begin
                cmd.wr = 1'b1;
                if (cnt_reg == LAST_ADDR)
                    state_next = S_IDLE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: src/ssd_dp.sv
// Datapath: command capture, page memory with valid bits, byte modify, scan buffer and output.
// Depends on ssd_pkg (types, codes, glyph and lamp functions).
module ssd_dp #(
    parameter int PAGES = ssd_pkg::PAGES_DEFAULT,
    parameter int AW    = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ssd_pkg::request_t    request,
    input  ssd_pkg::cfg_t        cfg,
    input  ssd_pkg::ctl_cmd_t    cmd,
    input  logic [AW-1:0]        cnt,
    output ssd_pkg::ctl_status_t status,
    output ssd_pkg::result_t     result,
    output logic                 result_valid
);

    localparam int DEPTH = PAGES * ssd_pkg::BYTES_PER_PAGE;
    localparam int NB    = ssd_pkg::BYTES_PER_PAGE;

    ssd_pkg::request_t item_reg;
    logic [7:0]        glyph_reg;
    logic [7:0]        glyph_next;
    logic              ended_reg;
    logic              ended_next;

    logic [7:0]        mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [7:0]        rd_data_reg;
    logic              rd_valid_reg;

    logic [7:0]        scan_reg [NB];
    logic [2:0]        digit_reg;
    logic [2:0]        digit_next;
    ssd_pkg::result_t  result_reg;
    logic              result_valid_reg;

    logic              char_ok;
    logic              ended_mid;
    logic              ended_new;
    logic [7:0]        char_sel;
    logic              editable;
    logic              shown_ok;
    logic              is_latch;
    logic              is_clear;
    logic [1:0]        page;
    logic [7:0]        base;
    logic [7:0]        sum;
    logic [AW-1:0]     addr;
    logic [2:0]        bsel;
    logic [2:0]        dpos;
    logic [3:0]        dec3;
    logic              dot_lit;
    logic [7:0]        old;
    logic [7:0]        mask;
    logic [7:0]        wdata;
    logic              mem_we;

    // string handling for character writes
    always_comb
    begin
        char_ok   = (request.window == 2'd0) && (request.position < 3'(ssd_pkg::DIGITS));
        ended_mid = (request.position == 3'd0) ? 1'b0 : ended_reg;
        ended_new = (request.char_code == 8'h00) || ended_mid;
        char_sel  = ended_new ? 8'h20 : request.char_code;
        if (request.command == ssd_pkg::CMD_CHAR)
            glyph_next = ssd_pkg::glyph_of(char_sel);
        else
            glyph_next = ssd_pkg::glyph_of(request.char_code);
        ended_next = ended_reg;
        if (cmd.load && request.command == ssd_pkg::CMD_CHAR && char_ok)
            ended_next = ended_new;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg  <= request;
            glyph_reg <= glyph_next;
        end
    end

    assign editable = ({2'b00, cfg.edit_page} < 4'(PAGES));
    assign shown_ok = cfg.display_enable && ({2'b00, cfg.shown_page} < 4'(PAGES));
    assign is_latch = (item_reg.command == ssd_pkg::CMD_LATCH);
    assign is_clear = (item_reg.command == ssd_pkg::CMD_CLEAR);

    always_comb
    begin
        status          = '0;
        status.is_clear = is_clear;
        status.is_latch = is_latch;
        status.first    = 3'd1;
        status.last     = 3'd6;
        unique case (item_reg.command)
            ssd_pkg::CMD_CLEAR:
            begin
                status.first = 3'd0;
            end
            ssd_pkg::CMD_CHAR:
            begin
                status.skip  = (item_reg.window != 2'd0) || !editable ||
                               (item_reg.position >= 3'(ssd_pkg::DIGITS));
                status.first = 3'd6 - item_reg.position;
                status.last  = 3'd6 - item_reg.position;
            end
            ssd_pkg::CMD_IND:
            begin
                status.skip  = !editable || (item_reg.indicator[5:4] != 2'b00);
                status.first = 3'd0;
                status.last  = 3'd0;
            end
            ssd_pkg::CMD_DOTS:
            begin
                status.skip = (item_reg.window != 2'd0) || !editable;
            end
            ssd_pkg::CMD_ALL:
            begin
                status.skip  = !editable;
                status.first = 3'd0;
            end
            ssd_pkg::CMD_FILL:
            begin
                status.skip = !editable;
            end
            ssd_pkg::CMD_LATCH:
            begin
                status.skip  = !shown_ok;
                status.first = 3'd0;
            end
            default:
            begin
                status.skip = 1'b1;
            end
        endcase
    end

    // address: page base plus byte, or a flat sweep for clear
    always_comb
    begin
        bsel = cnt[2:0];
        page = is_latch ? cfg.shown_page : cfg.edit_page;
        base = {6'd0, page} * 8'd7;
        sum  = base + {5'd0, bsel};
        addr = is_clear ? cnt : sum[AW-1:0];
    end

    always_comb
    begin
        old     = rd_valid_reg ? rd_data_reg : 8'h00;
        dpos    = bsel - 3'd1;
        dec3    = {1'b0, item_reg.decimal_pos} + 4'd3;
        dot_lit = ((item_reg.decimal_pos != 3'd0) &&
                   (item_reg.decimal_pos < 3'(ssd_pkg::DIGITS)) &&
                   (dpos == item_reg.decimal_pos)) ||
                  (item_reg.thousand_point && (dec3 < 4'(ssd_pkg::DIGITS)) &&
                   ({1'b0, dpos} == dec3));
        mask    = 8'h00;
        case (item_reg.command) inside
            ssd_pkg::CMD_CHAR, ssd_pkg::CMD_FILL:
            begin
                wdata = glyph_reg;
            end
            ssd_pkg::CMD_IND:
            begin
                mask  = ssd_pkg::lamp_mask(cfg.indicator_layout, item_reg.indicator[3:0]);
                wdata = item_reg.set_on ? (old | mask) : (old & ~mask);
            end
            ssd_pkg::CMD_DOTS:
            begin
                wdata = {dot_lit, old[6:0]};
            end
            ssd_pkg::CMD_ALL:
            begin
                mask  = (bsel == 3'd0) ? ssd_pkg::lamp_union(cfg.indicator_layout) : 8'h80;
                wdata = item_reg.set_on ? (old | mask) : (old & ~mask);
            end
            default:
            begin
                wdata = 8'h00;
            end
        endcase
    end

    assign mem_we = cmd.wr && !is_latch;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr] <= wdata;
        if (cmd.rd)
            rd_data_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
                valid_reg[addr] <= 1'b1;
            if (cmd.rd)
                rd_valid_reg <= valid_reg[addr];
        end
    end

    assign digit_next = (digit_reg == 3'(NB - 1)) ? 3'd0 : digit_reg + 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NB; i++)
            begin
                scan_reg[i] <= 8'h00;
            end
            digit_reg        <= 3'd0;
            ended_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            ended_reg        <= ended_next;
            result_valid_reg <= cmd.tick;
            if (cmd.blank)
            begin
                for (int i = 0; i < NB; i++)
                begin
                    scan_reg[i] <= 8'h00;
                end
            end
            else if (cmd.wr && is_latch)
                scan_reg[bsel] <= old;
            if (cmd.tick)
                digit_reg <= digit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick)
        begin
            result_reg.segment_pattern <= scan_reg[digit_reg];
            result_reg.digit_select    <= digit_reg;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule
